/* sv/drmap_pkg.sv */
// ----------------------------------------------------------------------------
// drmap_pkg
// Shared widths, coefficients and channel arithmetic for the dark map restyle.
// ----------------------------------------------------------------------------
package drmap_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned IN_W    = CH_W * NUM_CH;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned LAT     = 4;

    // channel order inside the request data, lowest bits first
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    localparam logic [16:0] LUMA_KR   = 17'd77;
    localparam logic [16:0] LUMA_KG   = 17'd150;
    localparam logic [16:0] LUMA_KB   = 17'd29;
    localparam logic [16:0] LUMA_RND  = 17'd128;
    localparam logic [15:0] DARK_GAIN = 16'd207;
    localparam logic [15:0] DARK_RND  = 16'd128;
    localparam logic [7:0]  DARK_BASE = 8'd14;
    localparam logic [7:0]  CH_MAX    = 8'd255;

    typedef logic        [CH_W-1:0] chan_t;
    typedef logic signed [CH_W:0]   delta_t;   // channel minus luma
    typedef logic signed [CH_W-1:0] adj_t;     // rounded 3/8 of delta
    typedef logic signed [CH_W+1:0] sum_t;     // dark luma plus adjustment

    // 3*d/8, halves away from zero
    function automatic adj_t round_3_8(input delta_t delta);
        logic signed [10:0] scaled;
        logic        [9:0]  mag;
        logic        [6:0]  q;
        scaled = {{2{delta[CH_W]}}, delta} + {delta[CH_W], delta, 1'b0};
        mag    = scaled[10] ? 10'(-scaled) : scaled[9:0];
        q      = 7'(({1'b0, mag} + 11'd4) >> 3);
        return scaled[10] ? -adj_t'({1'b0, q}) : adj_t'({1'b0, q});
    endfunction

    function automatic chan_t sat_chan(input sum_t v);
        if (v[CH_W+1]) begin
            return '0;
        end else if (v[CH_W]) begin
            return CH_MAX;
        end
        return v[CH_W-1:0];
    endfunction

endpackage

/* sv/dark_map_pixel_restyle_rgb565.sv */
// ----------------------------------------------------------------------------
// dark_map_pixel_restyle_rgb565
// Restyles 8-bit RGB pixels into dark-theme RGB565 pixels.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock whenever the result side is taking data.
// Four register stages carry each request: luma, dark luma with channel
// deltas, rounded 3/8 adjustment, then saturate and pack into the output
// register. The whole pipe advances on one enable, so s_tready is low only
// while a finished result waits on m_tready.
module dark_map_pixel_restyle_rgb565 (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [drmap_pkg::IN_W-1:0]  s_tdata,   // red_in, green_in, blue_in
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [drmap_pkg::OUT_W-1:0] m_tdata    // pixel_out
);
    import drmap_pkg::*;

    logic                pipe_en;
    logic [LAT-1:0]      vld_reg;
    logic [LAT-1:0]      vld_next;

    chan_t  s1_chan_reg  [NUM_CH];
    chan_t  s1_luma_reg;
    chan_t  s1_luma_next;
    chan_t  s2_dark_reg;
    chan_t  s2_dark_next;
    delta_t s2_delta_reg [NUM_CH];
    delta_t s2_delta_next[NUM_CH];
    chan_t  s3_dark_reg;
    adj_t   s3_adj_reg   [NUM_CH];
    adj_t   s3_adj_next  [NUM_CH];
    chan_t  s4_chan      [NUM_CH];
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    assign pipe_en  = !vld_reg[LAT-1] || m_tready;
    assign s_tready = pipe_en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: luma
    always_comb begin
        s1_luma_next = 8'((17'(s_tdata[CH_RED*CH_W +: CH_W]) * LUMA_KR
                         + 17'(s_tdata[CH_GREEN*CH_W +: CH_W]) * LUMA_KG
                         + 17'(s_tdata[CH_BLUE*CH_W +: CH_W]) * LUMA_KB
                         + LUMA_RND) >> 8);
    end

    // stage 2: dark luma and per-channel deltas
    always_comb begin
        s2_dark_next = DARK_BASE + 8'(({8'd0, CH_MAX - s1_luma_reg} * DARK_GAIN
                                       + DARK_RND) >> 8);
        for (int i = 0; i < NUM_CH; i++) begin
            s2_delta_next[i] = $signed({1'b0, s1_chan_reg[i]}) - $signed({1'b0, s1_luma_reg});
        end
    end

    // stage 3: rounded three eighths of each delta
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            s3_adj_next[i] = round_3_8(s2_delta_reg[i]);
        end
    end

    // stage 4: add, saturate, pack
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            s4_chan[i] = sat_chan($signed({2'b00, s3_dark_reg})
                                  + sum_t'(s3_adj_reg[i]));
        end
        out_next = {s4_chan[CH_RED][7:3], s4_chan[CH_GREEN][7:2], s4_chan[CH_BLUE][7:3]};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < NUM_CH; i++) begin
                s1_chan_reg[i]  <= s_tdata[i*CH_W +: CH_W];
                s2_delta_reg[i] <= s2_delta_next[i];
                s3_adj_reg[i]   <= s3_adj_next[i];
            end
            s1_luma_reg <= s1_luma_next;
            s2_dark_reg <= s2_dark_next;
            s3_dark_reg <= s2_dark_reg;
            out_reg     <= out_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;

endmodule

/* sv/drmap_checker.sv */
// ----------------------------------------------------------------------------
// drmap_checker
// Port-level checks on the dark map restyle pipeline.
// ----------------------------------------------------------------------------
module drmap_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [drmap_pkg::IN_W-1:0]  s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [drmap_pkg::OUT_W-1:0] m_tdata
);
    import drmap_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // the pipe only blocks requests while a finished result waits
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("request ready out of step with result side");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dark_map_pixel_restyle_rgb565 drmap_checker u_drmap_checker (.*);
